FILE: sv/polynomial_mutation_unit_defines.svh
// Assertion macros shared by the polynomial mutation unit.
`ifndef POLYNOMIAL_MUTATION_UNIT_DEFINES_SVH
`define POLYNOMIAL_MUTATION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMU_ASSERT_IMP(lbl, ante, cons, msg)
`define PMU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/pmu_pkg.sv
// Types, constants and codes shared by the polynomial mutation unit.
package pmu_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int RANDOM_BITS_DEF = 16;
  localparam int Q_BITS          = 30;
  localparam int DIV_W           = 61;
  localparam int DVS_W           = 34;

  localparam logic [31:0] ONE_Q = 32'h4000_0000;
  localparam logic [31:0] TWO_Q = 32'h8000_0000;
  localparam logic [31:0] CAP_Q = 32'hC000_0000;

  typedef struct packed {
    logic signed [31:0] current_value;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [15:0]        random_gate;
    logic [15:0]        random_shape;
    logic               last_variable;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic               was_mutated;
    logic               individual_changed;
    logic [31:0]        total_mutations;
  } out_item_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [7:0]  dist_index;
    logic        bounded;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    CFG_PROB    = 2'd0,
    CFG_INDEX   = 2'd1,
    CFG_BOUNDED = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ZERO_G,
    OP_DIV_G1,
    OP_DIV_G2,
    OP_DIV_INV,
    OP_DIV_STEP,
    OP_POW_INIT_R,
    OP_POW_INIT_T,
    OP_POW_MUL,
    OP_POW_SQ,
    OP_SAVE_G1,
    OP_SAVE_G2,
    OP_SIDE,
    OP_B1,
    OP_B2,
    OP_ROOT_TEST,
    OP_DELTA,
    OP_BOUND,
    OP_UMUL_LO,
    OP_UMUL_HI,
    OP_USAT,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    RET_G1,
    RET_G2,
    RET_ROOT,
    RET_INV
  } ret_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ZERO_G,
    ST_DIV_G1,
    ST_DIV_G2,
    ST_DIV_RUN,
    ST_POW_INIT,
    ST_POW_MUL,
    ST_POW_SQ,
    ST_SAVE_G1,
    ST_SAVE_G2,
    ST_SIDE,
    ST_B1,
    ST_B2,
    ST_ROOT_INIT,
    ST_ROOT_TEST,
    ST_INV,
    ST_DELTA,
    ST_BOUND,
    ST_UMUL_LO,
    ST_UMUL_HI,
    ST_USAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mutated;
    logic exp_bit;
    logic exp_done;
    logic div_last;
    logic bit_zero;
    logic c_zero;
  } dp_status_t;

endpackage

FILE: sv/pmu_datapath.sv
// Datapath: operand registers, shared multiplier, restoring divider and result logic.
module pmu_datapath #(
  parameter int FRAC_BITS   = pmu_pkg::FRAC_BITS_DEF,
  parameter int RANDOM_BITS = pmu_pkg::RANDOM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmu_pkg::dp_op_t      op,
  input  pmu_pkg::cfg_regs_t   cfg,
  input  pmu_pkg::in_item_t    in_data,
  output pmu_pkg::out_item_t   out_data,
  output pmu_pkg::dp_status_t  status
);
  import pmu_pkg::*;

  logic signed [31:0] y_r, yl_r, yu_r, nv_r;
  logic [15:0]        shape_r;
  logic               last_r, mut_r, left_r, neg_r, any_r;
  logic [30:0]        g1_r, g2_r;
  logic [31:0]        b_r, acc_r, base_r, c_r, count_r;
  logic [8:0]         exp_r;
  logic [4:0]         bit_r;
  logic [DVS_W-1:0]   rem_r, dvs_r;
  logic [DIV_W-1:0]   quot_r, mag_r;
  logic [5:0]         dcnt_r;
  logic [93:0]        uprod_r;
  out_item_t          out_r;

  logic [32:0]        full_w;
  logic [16:0]        s_w;
  logic [63:0]        rq_full;
  logic [30:0]        rq_w;
  logic [31:0]        den_w, two_m_g1, two_m_g2, one_m_rq;
  logic [30:0]        num_w;
  logic [63:0]        num_sh;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [33:0]        psh;
  logic [31:0]        sat_w, t_w, tcap_w;
  logic [32:0]        dlo_w, dhi_w, rng_w, rng_neg;
  logic [31:0]        dlo_pos, dhi_pos, rmag;
  logic               rneg, sgn;
  logic [DVS_W:0]     rem_sh;
  logic               q_ge;
  logic [DIV_W-1:0]   inv_w, one61;
  logic               inv_ge;
  logic signed [63:0] y64, yl64, yu64, step64, sum64, cl64;
  logic signed [33:0] ys34, p34, us34;
  logic signed [31:0] usat_w;
  logic               big;
  logic               any_nxt, changed;

  assign full_w   = 33'd1 << RANDOM_BITS;
  assign s_w      = ({17'd0, shape_r} > full_w) ? full_w[16:0] : {1'b0, shape_r};
  assign rq_full  = ({47'd0, s_w} << Q_BITS) >> RANDOM_BITS;
  assign rq_w     = rq_full[30:0];
  assign two_m_g1 = TWO_Q - {1'b0, g1_r};
  assign two_m_g2 = TWO_Q - {1'b0, g2_r};
  assign one_m_rq = ONE_Q - {1'b0, rq_w};
  assign den_w    = two_m_g1 - {1'b0, g2_r};
  assign num_w    = ONE_Q[30:0] - g1_r;
  assign num_sh   = {33'd0, num_w} << RANDOM_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_POW_MUL: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      OP_POW_SQ: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      OP_SIDE: begin
        mul_a = {15'd0, s_w};
        mul_b = den_w;
      end
      OP_B1: begin
        mul_a = left_r ? two_m_g1 : {1'b0, g1_r};
        mul_b = one_m_rq;
      end
      OP_B2: begin
        mul_a = left_r ? {1'b0, g2_r} : two_m_g2;
        mul_b = {1'b0, rq_w};
      end
      OP_UMUL_LO: begin
        mul_a = mag_r[31:0];
        mul_b = rmag;
      end
      OP_UMUL_HI: begin
        mul_a = {3'd0, mag_r[60:32]};
        mul_b = rmag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign psh    = mul_p[63:30];
  assign sat_w  = (psh > {2'd0, CAP_Q}) ? CAP_Q : psh[31:0];
  assign t_w    = c_r | (32'd1 << bit_r);
  assign tcap_w = (t_w > CAP_Q) ? CAP_Q : t_w;

  assign dlo_w   = {y_r[31], y_r} - {yl_r[31], yl_r};
  assign dhi_w   = {yu_r[31], yu_r} - {y_r[31], y_r};
  assign dlo_pos = dlo_w[32] ? '0 : dlo_w[31:0];
  assign dhi_pos = dhi_w[32] ? '0 : dhi_w[31:0];
  assign rng_w   = dhi_w + dlo_w;
  assign rng_neg = 33'd0 - rng_w;
  assign rneg    = rng_w[32];
  assign rmag    = rneg ? rng_neg[31:0] : rng_w[31:0];
  assign sgn     = neg_r ^ rneg;

  assign rem_sh = {rem_r, quot_r[DIV_W-1]};
  assign q_ge   = rem_sh >= {1'b0, dvs_r};

  assign one61  = {29'd0, ONE_Q};
  assign inv_w  = (c_r == '0) ? (61'd1 << (2 * Q_BITS)) : quot_r;
  assign inv_ge = inv_w >= one61;

  assign y64    = {{32{y_r[31]}}, y_r};
  assign yl64   = {{32{yl_r[31]}}, yl_r};
  assign yu64   = {{32{yu_r[31]}}, yu_r};
  assign step64 = {3'd0, mag_r} >> (Q_BITS - FRAC_BITS);
  assign sum64  = neg_r ? y64 - step64 : y64 + step64;

  always_comb begin
    cl64 = sum64;
    if (cl64 < yl64) cl64 = yl64;
    if (cl64 > yu64) cl64 = yu64;
  end

  assign ys34 = {{2{y_r[31]}}, y_r};
  assign p34  = {2'd0, uprod_r[61:30]};
  assign us34 = sgn ? ys34 - p34 : ys34 + p34;
  assign big  = |uprod_r[93:62];

  always_comb begin
    if (big) begin
      usat_w = sgn ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (us34[33:31] != 3'b000 && us34[33:31] != 3'b111) begin
      usat_w = us34[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      usat_w = us34[31:0];
    end
  end

  assign any_nxt = any_r | mut_r;
  assign changed = last_r & any_nxt;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        y_r     <= in_data.current_value;
        yl_r    <= in_data.lower_bound;
        yu_r    <= in_data.upper_bound;
        shape_r <= in_data.random_shape;
        last_r  <= in_data.last_variable;
        nv_r    <= in_data.current_value;
      end
      OP_ZERO_G: begin
        g1_r <= '0;
        g2_r <= '0;
      end
      OP_DIV_G1: begin
        dvs_r  <= (34'd1 << FRAC_BITS) + {2'd0, dlo_pos};
        quot_r <= 61'd1 << (Q_BITS + FRAC_BITS);
        rem_r  <= '0;
        dcnt_r <= 6'(DIV_W - 1);
      end
      OP_DIV_G2: begin
        dvs_r  <= (34'd1 << FRAC_BITS) + {2'd0, dhi_pos};
        quot_r <= 61'd1 << (Q_BITS + FRAC_BITS);
        rem_r  <= '0;
        dcnt_r <= 6'(DIV_W - 1);
      end
      OP_DIV_INV: begin
        dvs_r  <= {2'd0, c_r};
        quot_r <= 61'd1 << (2 * Q_BITS);
        rem_r  <= '0;
        dcnt_r <= 6'(DIV_W - 1);
      end
      OP_DIV_STEP: begin
        rem_r  <= q_ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        quot_r <= {quot_r[DIV_W-2:0], q_ge};
        dcnt_r <= dcnt_r - 6'd1;
      end
      OP_POW_INIT_R: begin
        acc_r  <= ONE_Q;
        base_r <= (quot_r[31:0] > CAP_Q) ? CAP_Q : quot_r[31:0];
        exp_r  <= {1'b0, cfg.dist_index} + 9'd1;
      end
      OP_POW_INIT_T: begin
        acc_r  <= ONE_Q;
        base_r <= tcap_w;
        exp_r  <= {1'b0, cfg.dist_index} + 9'd1;
      end
      OP_POW_MUL: acc_r <= sat_w;
      OP_POW_SQ: begin
        base_r <= sat_w;
        exp_r  <= exp_r >> 1;
      end
      OP_SAVE_G1: g1_r <= acc_r[30:0];
      OP_SAVE_G2: g2_r <= acc_r[30:0];
      OP_SIDE: left_r <= (den_w != '0) && (mul_p <= num_sh);
      OP_B1: b_r <= mul_p[61:30];
      OP_B2: begin
        b_r   <= b_r + mul_p[61:30];
        c_r   <= '0;
        bit_r <= 5'd31;
      end
      OP_ROOT_TEST: begin
        if (acc_r <= b_r) c_r <= t_w;
        bit_r <= bit_r - 5'd1;
      end
      OP_DELTA: begin
        mag_r <= inv_ge ? inv_w - one61 : one61 - inv_w;
        neg_r <= left_r ? (inv_w > one61) : !inv_ge;
      end
      OP_BOUND: nv_r <= cl64[31:0];
      OP_UMUL_LO: uprod_r <= {30'd0, mul_p};
      OP_UMUL_HI: uprod_r <= ({30'd0, mul_p} << 32) + uprod_r;
      OP_USAT: nv_r <= usat_w;
      OP_FINISH: begin
        out_r.new_value          <= nv_r;
        out_r.was_mutated        <= mut_r;
        out_r.individual_changed <= changed;
        out_r.total_mutations    <= count_r + {31'd0, changed};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r   <= 1'b0;
      count_r <= '0;
      mut_r   <= 1'b0;
    end else if (op == OP_LOAD) begin
      mut_r <= {1'b0, in_data.random_gate} <= cfg.prob;
    end else if (op == OP_FINISH) begin
      any_r   <= last_r ? 1'b0 : any_nxt;
      count_r <= count_r + {31'd0, changed};
    end
  end

  assign out_data        = out_r;
  assign status.mutated  = mut_r;
  assign status.exp_bit  = exp_r[0];
  assign status.exp_done = (exp_r[8:1] == '0);
  assign status.div_last = (dcnt_r == '0);
  assign status.bit_zero = (bit_r == '0);
  assign status.c_zero   = (c_r == '0);

endmodule

FILE: sv/pmu_ctrl.sv
// Controller state machine that sequences the datapath operations for one item.
module pmu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                bounded,
  input  pmu_pkg::dp_status_t status,
  output pmu_pkg::dp_op_t     op
);
  import pmu_pkg::*;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!status.mutated) state_nxt = ST_DONE;
        else if (bounded)    state_nxt = ST_DIV_G1;
        else                 state_nxt = ST_ZERO_G;
      end
      ST_ZERO_G:    state_nxt = ST_SIDE;
      ST_DIV_G1: begin
        ret_nxt   = RET_G1;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_G2: begin
        ret_nxt   = RET_G2;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (status.div_last) state_nxt = (ret_r == RET_INV) ? ST_DELTA : ST_POW_INIT;
      end
      ST_POW_INIT:  state_nxt = ST_POW_MUL;
      ST_POW_MUL:   state_nxt = ST_POW_SQ;
      ST_POW_SQ: begin
        if (!status.exp_done)    state_nxt = ST_POW_MUL;
        else if (ret_r == RET_G1) state_nxt = ST_SAVE_G1;
        else if (ret_r == RET_G2) state_nxt = ST_SAVE_G2;
        else                     state_nxt = ST_ROOT_TEST;
      end
      ST_SAVE_G1:   state_nxt = ST_DIV_G2;
      ST_SAVE_G2:   state_nxt = ST_SIDE;
      ST_SIDE:      state_nxt = ST_B1;
      ST_B1:        state_nxt = ST_B2;
      ST_B2:        state_nxt = ST_ROOT_INIT;
      ST_ROOT_INIT: begin
        ret_nxt   = RET_ROOT;
        state_nxt = ST_POW_MUL;
      end
      ST_ROOT_TEST: state_nxt = status.bit_zero ? ST_INV : ST_ROOT_INIT;
      ST_INV: begin
        ret_nxt   = RET_INV;
        state_nxt = status.c_zero ? ST_DELTA : ST_DIV_RUN;
      end
      ST_DELTA:     state_nxt = bounded ? ST_BOUND : ST_UMUL_LO;
      ST_BOUND:     state_nxt = ST_DONE;
      ST_UMUL_LO:   state_nxt = ST_UMUL_HI;
      ST_UMUL_HI:   state_nxt = ST_USAT;
      ST_USAT:      state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:      if (in_valid) op = OP_LOAD;
      ST_ZERO_G:    op = OP_ZERO_G;
      ST_DIV_G1:    op = OP_DIV_G1;
      ST_DIV_G2:    op = OP_DIV_G2;
      ST_DIV_RUN:   op = OP_DIV_STEP;
      ST_POW_INIT:  op = OP_POW_INIT_R;
      ST_POW_MUL:   op = status.exp_bit ? OP_POW_MUL : OP_NONE;
      ST_POW_SQ:    op = status.exp_done ? OP_NONE : OP_POW_SQ;
      ST_SAVE_G1:   op = OP_SAVE_G1;
      ST_SAVE_G2:   op = OP_SAVE_G2;
      ST_SIDE:      op = OP_SIDE;
      ST_B1:        op = OP_B1;
      ST_B2:        op = OP_B2;
      ST_ROOT_INIT: op = OP_POW_INIT_T;
      ST_ROOT_TEST: op = OP_ROOT_TEST;
      ST_INV:       op = status.c_zero ? OP_NONE : OP_DIV_INV;
      ST_DELTA:     op = OP_DELTA;
      ST_BOUND:     op = OP_BOUND;
      ST_UMUL_LO:   op = OP_UMUL_LO;
      ST_UMUL_HI:   op = OP_UMUL_HI;
      ST_USAT:      op = OP_USAT;
      ST_DONE:      if (out_free) op = OP_FINISH;
      default:      op = OP_NONE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || (state_r == ST_DONE && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= RET_G1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/polynomial_mutation_unit.sv
// An item that does not mutate goes from the check state straight to the done state; the longest
// path is for one that does (bounded mode, index 255): three 61-step divides, two powers and
// a 32-step root search, on one 32x32 multiplier and a 1-bit divider.
// One item at a time; the next item is accepted the cycle after its result is loaded, and
// an output stall holds the block in its done state until the result can be loaded.
// Reset (synchronous, active low) sets probability 0, index 20, bounded mode on, and clears the individual flag, count and result valid.
`include "polynomial_mutation_unit_defines.svh"
module polynomial_mutation_unit #(
  parameter int FRAC_BITS   = pmu_pkg::FRAC_BITS_DEF,
  parameter int RANDOM_BITS = pmu_pkg::RANDOM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pmu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pmu_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pmu_pkg::*;

  logic [16:0] prob_r;
  logic [7:0]  dist_r;
  logic        bounded_r;
  cfg_regs_t   cfg;
  dp_op_t      op;
  dp_status_t  status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r    <= '0;
      dist_r    <= 8'd20;
      bounded_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROB:    prob_r    <= cfg_data[16:0];
        CFG_INDEX:   dist_r    <= cfg_data[7:0];
        CFG_BOUNDED: bounded_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.prob       = prob_r;
  assign cfg.dist_index = dist_r;
  assign cfg.bounded    = bounded_r;

  pmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bounded   (bounded_r),
    .status    (status),
    .op        (op)
  );

  pmu_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data),
    .status   (status)
  );

  `PMU_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted but block not busy")
  `PMU_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")

endmodule
